// ----- hdl/pts_pkg.sv -----
`default_nettype none
package pts_pkg;

    localparam int COORD_W    = 32;
    localparam int FRAC_W     = 30;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int NORM_W     = 64;
    localparam int T_W        = 33;
    localparam int ROOT_W     = NORM_W / 2;
    localparam int DIV_STEPS  = T_W - 1;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int RADIUS_W   = 23;
    localparam int EPS_W      = 31;
    localparam int DIST_W     = 24;
    localparam int CFG_DATA_W = EPS_W;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic [COORD_W-1:0]        t_mag;
    typedef logic [NORM_W-1:0]         t_norm;
    typedef logic [T_W-1:0]            t_ratio;
    typedef logic [ROOT_W-1:0]         t_root;
    typedef logic [DIST_W-1:0]         t_dist;

    localparam t_coord Q_ONE    = t_coord'(1) <<< FRAC_W;
    localparam t_dist  DIST_MAX = '1;

    // register indexes
    localparam logic CFG_EARTH_RADIUS = 1'b0;
    localparam logic CFG_DEGEN_EPS    = 1'b1;

    typedef enum logic [1:0] {
        KIND_PROJ  = 2'd0,
        KIND_END_A = 2'd1,
        KIND_END_B = 2'd2,
        KIND_DEGEN = 2'd3
    } t_kind;

    typedef struct packed {
        t_coord [2:0] p;
        t_coord [2:0] a;
        t_coord [2:0] b;
        t_mag   [2:0] ba_mag;
        logic   [2:0] ba_neg;
        logic         degen;
        logic         opp;
        logic         near_a;
        logic         den_zero;
    } t_div_side;

    typedef struct packed {
        t_coord [2:0] near;
        t_kind        kind;
    } t_sqrt_side;

endpackage
`default_nettype wire

// ----- hdl/point_to_segment_distance_3d.sv -----
// Throughput: one transaction per clock while results are taken; the
// 34-stage divider and the 32-stage square root are fully pipelined, so
// back-to-back transactions flow.
// When a result is not taken, the whole pipeline holds in place.
// Reset (synchronous, active low) clears all valid bits and loads the
// register defaults: earth radius 6371000, degenerate epsilon 1.
`default_nettype none
module point_to_segment_distance_3d import pts_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_coord                i_point_x,
    input  wire t_coord                i_point_y,
    input  wire t_coord                i_point_z,
    input  wire t_coord                i_seg_a_x,
    input  wire t_coord                i_seg_a_y,
    input  wire t_coord                i_seg_a_z,
    input  wire t_coord                i_seg_b_x,
    input  wire t_coord                i_seg_b_y,
    input  wire t_coord                i_seg_b_z,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_dist                      o_distance_m,
    output t_coord                     o_near_x,
    output t_coord                     o_near_y,
    output t_coord                     o_near_z,
    output logic [1:0]                 o_near_kind,
    input  wire logic                  i_cfg_wen,
    input  wire logic                  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int STEP_PROD_W = COORD_W + T_W;
    localparam int SCALE_W     = RADIUS_W + ROOT_W;
    localparam logic [STEP_PROD_W-1:0] STEP_HALF = STEP_PROD_W'(1) << (T_W - 2);
    localparam logic [SCALE_W-1:0]     DIST_HALF = SCALE_W'(1) << (FRAC_W - 1);

    logic [RADIUS_W-1:0] r_earth_radius;
    logic [EPS_W-1:0]    r_degen_eps;

    logic         w_en;
    t_coord [2:0] w_p, w_a, w_b;

    logic         f_valid;
    t_norm        f_num, f_den;
    t_div_side    f_side;

    logic         d_valid;
    t_ratio       d_t;
    t_div_side    d_side;

    logic                          r1_valid;
    logic [2:0][STEP_PROD_W-1:0]   r1_prod;
    t_div_side                     r1_side;

    logic         r2_valid;
    t_coord [2:0] r2_p;
    t_sqrt_side   r2_side;

    logic         r3_valid;
    t_prod  [2:0] r3_sq;
    t_sqrt_side   r3_side;

    logic         r4_valid;
    t_norm        r4_sq;
    t_sqrt_side   r4_side;

    logic         s_valid;
    t_root        s_root;
    t_sqrt_side   s_side;

    logic               r5_valid;
    logic [SCALE_W-1:0] r5_scaled;
    t_sqrt_side         r5_side;

    t_mag   [2:0] n2_step;
    t_coord [2:0] n2_proj;
    t_sqrt_side   n2_side;
    t_diff  [2:0] n3_pn;
    logic [SCALE_W-1:0] n6_round;

    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    assign w_p[0] = i_point_x;
    assign w_p[1] = i_point_y;
    assign w_p[2] = i_point_z;
    assign w_a[0] = i_seg_a_x;
    assign w_a[1] = i_seg_a_y;
    assign w_a[2] = i_seg_a_z;
    assign w_b[0] = i_seg_b_x;
    assign w_b[1] = i_seg_b_y;
    assign w_b[2] = i_seg_b_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_earth_radius <= RADIUS_W'(6371000);
            r_degen_eps    <= EPS_W'(1);
        end else if (i_cfg_wen) begin
            case (i_cfg_addr)
                CFG_EARTH_RADIUS: r_earth_radius <= i_cfg_data[RADIUS_W-1:0];
                CFG_DEGEN_EPS:    r_degen_eps    <= i_cfg_data[EPS_W-1:0];
                default:          r_degen_eps    <= r_degen_eps;
            endcase
        end
    end

    pts_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_p     (w_p),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_eps   (r_degen_eps),
        .o_valid (f_valid),
        .o_num   (f_num),
        .o_den   (f_den),
        .o_side  (f_side)
    );

    pts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (f_valid),
        .i_num   (f_num),
        .i_den   (f_den),
        .i_side  (f_side),
        .o_valid (d_valid),
        .o_t     (d_t),
        .o_side  (d_side)
    );

    // projection step, then case selection
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n2_step[i] = t_mag'((r1_prod[i] + STEP_HALF) >> (T_W - 1));
            n2_proj[i] = t_coord'(r1_side.ba_neg[i]
                ? t_diff'(r1_side.a[i]) - t_diff'({1'b0, n2_step[i]})
                : t_diff'(r1_side.a[i]) + t_diff'({1'b0, n2_step[i]}));
        end
        if (r1_side.degen) begin
            n2_side.near = r1_side.a;
            n2_side.kind = KIND_DEGEN;
        end else if (r1_side.opp) begin
            n2_side.near = r1_side.near_a ? r1_side.a : r1_side.b;
            n2_side.kind = r1_side.near_a ? KIND_END_A : KIND_END_B;
        end else if (r1_side.den_zero) begin
            n2_side.near = r1_side.a;
            n2_side.kind = KIND_DEGEN;
        end else begin
            n2_side.near = n2_proj;
            n2_side.kind = KIND_PROJ;
        end
        for (int i = 0; i < 3; i++) begin
            n3_pn[i] = t_diff'(r2_p[i]) - t_diff'(r2_side.near[i]);
        end
        n6_round = (r5_scaled + DIST_HALF) >> FRAC_W;
    end

    pts_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r4_valid),
        .i_sq    (r4_sq),
        .i_side  (r4_side),
        .o_valid (s_valid),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r5_valid    <= 1'b0;
            o_out_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid    <= d_valid;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r4_valid    <= r3_valid;
            r5_valid    <= s_valid;
            o_out_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_prod[i] <= d_side.ba_mag[i] * d_t;
                r3_sq[i]   <= n3_pn[i] * n3_pn[i];
            end
            r1_side <= d_side;

            r2_p    <= r1_side.p;
            r2_side <= n2_side;

            r3_side <= r2_side;

            r4_sq   <= t_norm'(r3_sq[0] + r3_sq[1] + r3_sq[2]);
            r4_side <= r3_side;

            r5_scaled <= r_earth_radius * s_root;
            r5_side   <= s_side;

            o_distance_m <= (n6_round > SCALE_W'(DIST_MAX)) ? DIST_MAX
                                                            : t_dist'(n6_round);
            o_near_x     <= r5_side.near[0];
            o_near_y     <= r5_side.near[1];
            o_near_z     <= r5_side.near[2];
            o_near_kind  <= r5_side.kind;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/pts_front.sv -----
`default_nettype none
module pts_front import pts_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire t_coord [2:0]      i_p,
    input  wire t_coord [2:0]      i_a,
    input  wire t_coord [2:0]      i_b,
    input  wire logic [EPS_W-1:0]  i_eps,
    output logic                   o_valid,
    output t_norm                  o_num,
    output t_norm                  o_den,
    output t_div_side              o_side
);

    function automatic t_coord sat(input t_coord v);
        t_coord r;
        r = v;
        if (v > Q_ONE)  r = Q_ONE;
        if (v < -Q_ONE) r = -Q_ONE;
        return r;
    endfunction

    // stage 1: saturated coordinates
    logic         r1_valid;
    t_coord [2:0] r1_p, r1_a, r1_b;
    // stage 2: differences
    logic         r2_valid, r2_degen;
    t_diff  [2:0] r2_pa, r2_pb, r2_ba;
    t_coord [2:0] r2_p, r2_a, r2_b;
    // stage 3: products
    logic         r3_valid, r3_degen;
    t_prod  [2:0] r3_m1, r3_m2, r3_qa, r3_qb, r3_qd;
    t_coord [2:0] r3_p, r3_a, r3_b;
    t_diff  [2:0] r3_ba;
    // stage 4: sums
    logic         r4_valid, r4_degen;
    t_prod        r4_v1, r4_w2, r4_npa, r4_npb, r4_den;
    t_coord [2:0] r4_p, r4_a, r4_b;
    t_diff  [2:0] r4_ba;

    t_diff  [2:0] n2_pa, n2_pb, n2_ba;
    t_mag   [2:0] n2_mag;
    logic         n2_degen;
    t_mag   [2:0] n5_mag;

    always_comb begin
        n2_degen = 1'b1;
        for (int i = 0; i < 3; i++) begin
            n2_pa[i]  = t_diff'(r1_p[i]) - t_diff'(r1_a[i]);
            n2_pb[i]  = t_diff'(r1_p[i]) - t_diff'(r1_b[i]);
            n2_ba[i]  = t_diff'(r1_b[i]) - t_diff'(r1_a[i]);
            n2_mag[i] = t_mag'(n2_ba[i][DIFF_W-1] ? -n2_ba[i] : n2_ba[i]);
            if (n2_mag[i] >= t_mag'(i_eps)) n2_degen = 1'b0;
            n5_mag[i] = t_mag'(r4_ba[i][DIFF_W-1] ? -r4_ba[i] : r4_ba[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            o_valid  <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            o_valid  <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_p[i] <= sat(i_p[i]);
                r1_a[i] <= sat(i_a[i]);
                r1_b[i] <= sat(i_b[i]);

                r3_m1[i] <= r2_pa[i] * r2_ba[i];
                r3_m2[i] <= r2_pb[i] * r2_ba[i];
                r3_qa[i] <= r2_pa[i] * r2_pa[i];
                r3_qb[i] <= r2_pb[i] * r2_pb[i];
                r3_qd[i] <= r2_ba[i] * r2_ba[i];

                o_side.ba_mag[i] <= n5_mag[i];
                o_side.ba_neg[i] <= r4_ba[i][DIFF_W-1];
            end
            r2_pa    <= n2_pa;
            r2_pb    <= n2_pb;
            r2_ba    <= n2_ba;
            r2_degen <= n2_degen;
            r2_p     <= r1_p;
            r2_a     <= r1_a;
            r2_b     <= r1_b;

            r3_p     <= r2_p;
            r3_a     <= r2_a;
            r3_b     <= r2_b;
            r3_ba    <= r2_ba;
            r3_degen <= r2_degen;

            r4_v1    <= r3_m1[0] + r3_m1[1] + r3_m1[2];
            // (P-B).(A-B) is the negative of this sum
            r4_w2    <= r3_m2[0] + r3_m2[1] + r3_m2[2];
            r4_npa   <= r3_qa[0] + r3_qa[1] + r3_qa[2];
            r4_npb   <= r3_qb[0] + r3_qb[1] + r3_qb[2];
            r4_den   <= r3_qd[0] + r3_qd[1] + r3_qd[2];
            r4_p     <= r3_p;
            r4_a     <= r3_a;
            r4_b     <= r3_b;
            r4_ba    <= r3_ba;
            r4_degen <= r3_degen;

            o_num           <= (r4_v1 > 0) ? t_norm'(r4_v1) : '0;
            o_den           <= t_norm'(r4_den);
            o_side.p        <= r4_p;
            o_side.a        <= r4_a;
            o_side.b        <= r4_b;
            o_side.degen    <= r4_degen;
            o_side.opp      <= (r4_v1 > 0 && r4_w2 > 0) || (r4_v1 < 0 && r4_w2 < 0);
            o_side.near_a   <= r4_npa < r4_npb;
            o_side.den_zero <= (r4_den == 0);
        end
    end

endmodule
`default_nettype wire

// ----- hdl/pts_div.sv -----
`default_nettype none
module pts_div import pts_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_en,
    input  wire logic      i_valid,
    input  wire t_norm     i_num,
    input  wire t_norm     i_den,
    input  wire t_div_side i_side,
    output logic           o_valid,
    output t_ratio         o_t,
    output t_div_side      o_side
);

    // one quotient bit per stage; when num <= den the remainder stays below den
    logic [DIV_STEPS:0] r_valid;
    t_norm              r_rem  [0:DIV_STEPS];
    t_ratio             r_quo  [0:DIV_STEPS];
    t_norm              r_den  [0:DIV_STEPS];
    t_div_side          r_side [0:DIV_STEPS];

    t_norm              n_rem  [0:DIV_STEPS];
    t_ratio             n_quo  [0:DIV_STEPS];
    logic [NORM_W:0]    w_dbl  [1:DIV_STEPS];
    logic               w_take [1:DIV_STEPS];
    logic [NORM_W:0]    w_last;
    t_ratio             n_t;

    always_comb begin
        n_quo[0] = t_ratio'(i_num >= i_den);
        n_rem[0] = (i_num >= i_den) ? i_num - i_den : i_num;
        for (int k = 1; k <= DIV_STEPS; k++) begin
            w_dbl[k]  = {r_rem[k-1], 1'b0};
            w_take[k] = w_dbl[k] >= {1'b0, r_den[k-1]};
            n_rem[k]  = w_take[k] ? t_norm'(w_dbl[k] - {1'b0, r_den[k-1]})
                                  : t_norm'(w_dbl[k]);
            n_quo[k]  = {r_quo[k-1][T_W-2:0], w_take[k]};
        end
        // round half up
        w_last = {r_rem[DIV_STEPS], 1'b0};
        n_t    = r_quo[DIV_STEPS] + t_ratio'(w_last >= {1'b0, r_den[DIV_STEPS]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= {r_valid[DIV_STEPS-1:0], i_valid};
            o_valid <= r_valid[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
            for (int k = 0; k <= DIV_STEPS; k++) begin
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
            end
            for (int k = 1; k <= DIV_STEPS; k++) begin
                r_den[k]  <= r_den[k-1];
                r_side[k] <= r_side[k-1];
            end
            o_t    <= n_t;
            o_side <= r_side[DIV_STEPS];
        end
    end

endmodule
`default_nettype wire

// ----- hdl/pts_sqrt.sv -----
`default_nettype none
module pts_sqrt import pts_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire logic       i_valid,
    input  wire t_norm      i_sq,
    input  wire t_sqrt_side i_side,
    output logic            o_valid,
    output t_root           o_root,
    output t_sqrt_side      o_side
);

    logic [SQRT_STEPS-1:0] r_valid;
    t_norm                 r_x    [0:SQRT_STEPS-1];
    t_norm                 r_res  [0:SQRT_STEPS-1];
    t_sqrt_side            r_side [0:SQRT_STEPS-1];

    t_norm w_x_in  [0:SQRT_STEPS-1];
    t_norm w_res_in[0:SQRT_STEPS-1];
    t_norm w_bit   [0:SQRT_STEPS-1];
    t_norm w_trial [0:SQRT_STEPS-1];
    t_norm n_x     [0:SQRT_STEPS-1];
    t_norm n_res   [0:SQRT_STEPS-1];

    // digit-by-digit root, one result bit per stage, trial bit walks down by 4x
    always_comb begin
        for (int k = 0; k < SQRT_STEPS; k++) begin
            w_x_in[k]   = (k == 0) ? i_sq : r_x[(k == 0) ? 0 : k-1];
            w_res_in[k] = (k == 0) ? '0   : r_res[(k == 0) ? 0 : k-1];
            w_bit[k]    = t_norm'(1) << (2 * (SQRT_STEPS - 1 - k));
            w_trial[k]  = w_res_in[k] + w_bit[k];
            if (w_x_in[k] >= w_trial[k]) begin
                n_x[k]   = w_x_in[k] - w_trial[k];
                n_res[k] = (w_res_in[k] >> 1) + w_bit[k];
            end else begin
                n_x[k]   = w_x_in[k];
                n_res[k] = w_res_in[k] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[SQRT_STEPS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 0; k < SQRT_STEPS; k++) begin
                r_x[k]   <= n_x[k];
                r_res[k] <= n_res[k];
            end
            for (int k = 1; k < SQRT_STEPS; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_valid[SQRT_STEPS-1];
    assign o_root  = r_res[SQRT_STEPS-1][ROOT_W-1:0];
    assign o_side  = r_side[SQRT_STEPS-1];

endmodule
`default_nettype wire

// ----- hdl/pts_checker.sv -----
`default_nettype none
module pts_checker import pts_pkg::*; (
    input wire logic   i_clk,
    input wire logic   i_rst_n,
    input wire logic   o_in_ready,
    input wire logic   o_out_valid,
    input wire logic   i_out_ready,
    input wire t_dist  o_distance_m,
    input wire t_coord o_near_x,
    input wire t_coord o_near_y,
    input wire t_coord o_near_z,
    input wire logic [1:0] o_near_kind
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_distance_m) && $stable(o_near_kind))
        else $error("stalled result changed or dropped");

    a_no_take_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("transaction taken while pipeline is held");

    a_near_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            o_near_x <= Q_ONE && o_near_x >= -Q_ONE &&
            o_near_y <= Q_ONE && o_near_y >= -Q_ONE &&
            o_near_z <= Q_ONE && o_near_z >= -Q_ONE)
        else $error("nearest point outside unit range");

endmodule

bind point_to_segment_distance_3d pts_checker u_pts_checker (.*);
`default_nettype wire
